### rtl/gfpc_pkg.sv
// ----------------------------------------------------------------------------
// gfpc_pkg
// Shared types and constants for the GIF frame pixel compositor: command
// codes, register indexes, index modes, the register set and the interlace
// pass tables.
// ----------------------------------------------------------------------------
package gfpc_pkg;

   // Input word commands
   typedef enum logic [1:0] {
      CMD_PAL_WRITE = 2'd0,
      CMD_PIXEL     = 2'd1,
      CMD_START     = 2'd2,
      CMD_RESERVED  = 2'd3
   } cmd_type;

   // Register indexes on the CSR port
   typedef enum logic [2:0] {
      CSR_FRAME_LEFT   = 3'd0,
      CSR_FRAME_TOP    = 3'd1,
      CSR_FRAME_WIDTH  = 3'd2,
      CSR_FRAME_HEIGHT = 3'd3,
      CSR_INTERLACED   = 3'd4,
      CSR_INDEX_MODE   = 3'd5,
      CSR_TRANSP_INDEX = 3'd6,
      CSR_BG_INDEX     = 3'd7
   } csr_addr_type;

   // Transparency handling; the reserved mode behaves as no control extension
   localparam logic [1:0] MODE_NONE       = 2'd0;
   localparam logic [1:0] MODE_BACKGROUND = 2'd1;
   localparam logic [1:0] MODE_SKIP       = 2'd2;
   localparam logic [1:0] MODE_RESERVED   = 2'd3;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // Register set
   typedef struct packed {
      logic [15:0] frame_left;
      logic [15:0] frame_top;
      logic [15:0] frame_width;
      logic [15:0] frame_height;
      logic        interlaced;
      logic [1:0]  index_mode;
      logic [7:0]  transparent_index;
      logic [7:0]  background_index;
   } cfg_type;

   // Position of the current pixel, from the raster counters
   typedef struct packed {
      logic        active;
      logic [16:0] dest_x;
      logic [16:0] dest_y;
      logic        done;
   } pos_type;

   // First row of each interlace pass
   function automatic logic [3:0] pass_start(input logic [1:0] pass);
      logic [3:0] row;
      case (pass)
         2'd0:    row = 4'd0;
         2'd1:    row = 4'd4;
         2'd2:    row = 4'd2;
         default: row = 4'd1;
      endcase
      return row;
   endfunction

   // Row step of each interlace pass
   function automatic logic [3:0] pass_step(input logic [1:0] pass);
      logic [3:0] step;
      case (pass)
         2'd0:    step = 4'd8;
         2'd1:    step = 4'd8;
         2'd2:    step = 4'd4;
         default: step = 4'd2;
      endcase
      return step;
   endfunction

endpackage

### rtl/gfpc_csr.sv
// ----------------------------------------------------------------------------
// gfpc_csr
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module gfpc_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [2:0]           csr_addr,
   input  logic [15:0]          csr_wdata,
   output gfpc_pkg::cfg_type    cfg
);

   gfpc_pkg::cfg_type      cfg_ff;
   gfpc_pkg::cfg_type      cfg_in;
   gfpc_pkg::csr_addr_type addr;

   assign addr = gfpc_pkg::csr_addr_type'(csr_addr);

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (addr)
            gfpc_pkg::CSR_FRAME_LEFT:   cfg_in.frame_left        = csr_wdata;
            gfpc_pkg::CSR_FRAME_TOP:    cfg_in.frame_top         = csr_wdata;
            gfpc_pkg::CSR_FRAME_WIDTH:  cfg_in.frame_width       = csr_wdata;
            gfpc_pkg::CSR_FRAME_HEIGHT: cfg_in.frame_height      = csr_wdata;
            gfpc_pkg::CSR_INTERLACED:   cfg_in.interlaced        = csr_wdata[0];
            gfpc_pkg::CSR_INDEX_MODE:   cfg_in.index_mode        = csr_wdata[1:0];
            gfpc_pkg::CSR_TRANSP_INDEX: cfg_in.transparent_index = csr_wdata[7:0];
            gfpc_pkg::CSR_BG_INDEX:     cfg_in.background_index  = csr_wdata[7:0];
         endcase
      end
   end

   // Width and height reset to one, everything else to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{frame_left:        16'd0,
                     frame_top:         16'd0,
                     frame_width:       16'd1,
                     frame_height:      16'd1,
                     interlaced:        1'b0,
                     index_mode:        gfpc_pkg::MODE_NONE,
                     transparent_index: 8'd0,
                     background_index:  8'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/gfpc_palette.sv
// ----------------------------------------------------------------------------
// gfpc_palette
// Colour palette memory: one write and one registered read per cycle.
// Slots at or above the depth are not stored and read as black.
// ----------------------------------------------------------------------------
module gfpc_palette #(
   parameter int unsigned PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [7:0]  wr_slot,
   input  logic [23:0] wr_rgb,
   input  logic        rd_en,
   input  logic [7:0]  rd_slot,
   output logic [23:0] rd_rgb
);

   localparam int unsigned ADDR_W  = $clog2(PALETTE_DEPTH);
   localparam logic [8:0]  SLOT_LIM = 9'(PALETTE_DEPTH);

   logic [23:0] mem [PALETTE_DEPTH];
   logic [23:0] rd_data_ff;
   logic        rd_hit_ff;
   logic        wr_hit;
   logic        rd_hit;

   assign wr_hit = {1'b0, wr_slot} < SLOT_LIM;
   assign rd_hit = {1'b0, rd_slot} < SLOT_LIM;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en && wr_hit) begin
         mem[wr_slot[ADDR_W-1:0]] <= wr_rgb;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_slot[ADDR_W-1:0]];
         rd_hit_ff  <= rd_hit;
      end
   end

   assign rd_rgb = rd_hit_ff ? rd_data_ff : 24'd0;

endmodule

### rtl/gfpc_raster.sv
// ----------------------------------------------------------------------------
// gfpc_raster
// Column, row and interlace pass counters. Gives the canvas position of the
// pixel at the input; steps on each accepted pixel word, clears on a start.
// ----------------------------------------------------------------------------
module gfpc_raster (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [1:0]           command,
   input  gfpc_pkg::cfg_type    cfg,
   output gfpc_pkg::pos_type    pos
);

   logic [15:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;
   logic [1:0]  pass_ff, pass_in;
   logic        finished_ff, finished_in;

   logic [15:0] width_eff;
   logic [15:0] height_eff;
   logic [16:0] col_sum;
   logic        col_wrap;
   logic [16:0] row_seq;
   logic [16:0] row_il;
   logic [1:0]  pass_il;
   logic        end_il;
   logic        searching;
   logic [15:0] row_nx;
   logic [1:0]  pass_nx;
   logic        row_end;
   logic        is_pixel;

   assign width_eff  = (cfg.frame_width  == 16'd0) ? 16'd1 : cfg.frame_width;
   assign height_eff = (cfg.frame_height == 16'd0) ? 16'd1 : cfg.frame_height;

   // Column step; a carry out also ends the row
   assign col_sum  = {1'b0, col_ff} + 17'd1;
   assign col_wrap = col_sum[16] || (col_sum >= {1'b0, width_eff});

   // Sequential row advance
   assign row_seq = {1'b0, row_ff} + 17'd1;

   // Interlaced row advance: skip passes whose start row is past the height
   always_comb begin
      row_il    = {1'b0, row_ff} + 17'(gfpc_pkg::pass_step(pass_ff));
      pass_il   = pass_ff;
      end_il    = 1'b0;
      searching = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (searching && (row_il >= {1'b0, height_eff})) begin
            if (pass_il == 2'd3) begin
               end_il    = 1'b1;
               row_il    = 17'd0;
               searching = 1'b0;
            end else begin
               pass_il = pass_il + 2'd1;
               row_il  = 17'(gfpc_pkg::pass_start(pass_il));
            end
         end else begin
            searching = 1'b0;
         end
      end
   end

   always_comb begin
      if (cfg.interlaced) begin
         row_nx  = row_il[15:0];
         pass_nx = pass_il;
         row_end = end_il;
      end else begin
         row_nx  = row_seq[15:0];
         pass_nx = pass_ff;
         row_end = row_seq >= {1'b0, height_eff};
      end
   end

   assign is_pixel = (command == gfpc_pkg::CMD_PIXEL);

   // Position of the pixel at the input
   always_comb begin
      pos.active = is_pixel && !finished_ff;
      pos.dest_x = {1'b0, cfg.frame_left} + {1'b0, col_ff};
      pos.dest_y = {1'b0, cfg.frame_top}  + {1'b0, row_ff};
      pos.done   = pos.active && col_wrap && row_end;
   end

   // Counter update
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      pass_in     = pass_ff;
      finished_in = finished_ff;
      if (accept) begin
         if (command == gfpc_pkg::CMD_START) begin
            col_in      = 16'd0;
            row_in      = 16'd0;
            pass_in     = 2'd0;
            finished_in = 1'b0;
         end else if (pos.active) begin
            if (col_wrap) begin
               col_in      = 16'd0;
               row_in      = row_nx;
               pass_in     = pass_nx;
               finished_in = row_end;
            end else begin
               col_in = col_sum[15:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         pass_ff     <= '0;
         finished_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         pass_ff     <= pass_in;
         finished_ff <= finished_in;
      end
   end

endmodule

### rtl/gif_frame_pixel_compositor_core.sv
// ----------------------------------------------------------------------------
// gif_frame_pixel_compositor_core
// Turns decoded GIF colour indices into canvas positions and packed RGBA
// words, with palette load, transparency and four-pass interlace.
// ----------------------------------------------------------------------------
// One word is taken every clock cycle unless the output stalls, and each
// gives exactly one result word: the input stage does the palette write or
// read and the counter step, the output register holds the result until it
// is taken. The rate is set by the single read port of the palette memory.
// The palette is not cleared at reset; load every slot a frame uses before
// the frame. A frame ends with tlast on its last pixel; pixels after that
// give all-zero results until a start-frame word.
// ----------------------------------------------------------------------------
module gif_frame_pixel_compositor_core #(
   parameter int unsigned PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   // Input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // entry_index, red_in, green_in, blue_in
   input  logic [1:0]  req_tuser,   // command
   // Result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // write_pixel, dest_x, dest_y, pixel_word
   output logic        rsp_tlast,   // frame_done
   // Configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   gfpc_pkg::cfg_type cfg;
   gfpc_pkg::pos_type pos;

   logic        accept;
   logic        s1_adv;
   logic [7:0]  entry_index;
   logic [23:0] entry_rgb;
   logic        key_match;
   logic        pal_wr;
   logic [7:0]  rd_slot;
   logic        paint;
   logic [23:0] rd_rgb;

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_active_ff;
   logic        s1_paint_ff;
   logic [16:0] s1_x_ff;
   logic [16:0] s1_y_ff;
   logic        s1_done_ff;

   logic        out_valid_ff, out_valid_in;
   logic        out_write_ff;
   logic [16:0] out_x_ff;
   logic [16:0] out_y_ff;
   logic [31:0] out_word_ff;
   logic        out_done_ff;

   gfpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshake: input stage advances when the output register is free
   assign s1_adv     = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   assign entry_index = req_tdata[7:0];
   assign entry_rgb   = {req_tdata[31:24], req_tdata[23:16], req_tdata[15:8]};

   // Transparent index handling picks the palette slot to read
   assign key_match = ((cfg.index_mode == gfpc_pkg::MODE_BACKGROUND) ||
                       (cfg.index_mode == gfpc_pkg::MODE_SKIP)) &&
                      (entry_index == cfg.transparent_index);
   assign rd_slot   = (key_match && (cfg.index_mode == gfpc_pkg::MODE_BACKGROUND)) ?
                      cfg.background_index : entry_index;
   assign paint     = !(key_match && (cfg.index_mode == gfpc_pkg::MODE_SKIP));
   assign pal_wr    = accept && (req_tuser == gfpc_pkg::CMD_PAL_WRITE);

   gfpc_raster u_raster (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .command (req_tuser),
      .cfg     (cfg),
      .pos     (pos)
   );

   gfpc_palette #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr),
      .wr_slot (entry_index),
      .wr_rgb  (entry_rgb),
      .rd_en   (accept),
      .rd_slot (rd_slot),
      .rd_rgb  (rd_rgb)
   );

   // Input stage
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_active_ff <= pos.active;
         s1_paint_ff  <= paint;
         s1_x_ff      <= pos.dest_x;
         s1_y_ff      <= pos.dest_y;
         s1_done_ff   <= pos.done;
      end
   end

   // Output register
   always_comb begin
      if (s1_adv) begin
         out_valid_in = s1_valid_ff;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_adv) begin
         out_write_ff <= s1_active_ff && s1_paint_ff;
         out_x_ff     <= s1_active_ff ? s1_x_ff : 17'd0;
         out_y_ff     <= s1_active_ff ? s1_y_ff : 17'd0;
         out_word_ff  <= (s1_active_ff && s1_paint_ff) ?
                         {gfpc_pkg::ALPHA_OPAQUE, rd_rgb} : 32'd0;
         out_done_ff  <= s1_active_ff && s1_done_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_word_ff, out_y_ff, out_x_ff, out_write_ff};
   assign rsp_tlast  = out_done_ff;

`ifndef SYNTHESIS
   // A skipped or empty result carries no colour
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_write_ff) |-> (out_word_ff == 32'd0))
      else $error("non-zero word on a result without write");

   // A written pixel is always opaque
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_write_ff) |-> (out_word_ff[31:24] == gfpc_pkg::ALPHA_OPAQUE))
      else $error("written pixel without full alpha");

   // An empty input stage always takes a word
   assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("input stalled while empty");

   // A word in the input stage reaches the output on the next cycle when free
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_valid_ff) |=> out_valid_ff)
      else $error("input stage did not move to a free output");

   // Reset leaves no result pending
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");
`endif

endmodule

### verif/gif_frame_pixel_compositor_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gif_frame_pixel_compositor_core_test
// Self-checking bench for the GIF pixel compositor. Words are pushed on the
// req_ stream in bursts with random gaps while the rsp_ side stalls on a
// per-phase pattern. A behavioural model of palette, raster/interlace
// counters and transparency predicts each result word; the checker compares
// every field in order of arrival.
// ----------------------------------------------------------------------------
module gif_frame_pixel_compositor_core_test;

   // One result word, split into its fields
   typedef struct packed {
      logic        write_pixel;
      logic [16:0] dest_x;
      logic [16:0] dest_y;
      logic [31:0] pixel_word;
      logic        frame_done;
   } pixel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // entry_index, red_in, green_in, blue_in
   logic [1:0]  req_tuser = '0;   // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // write_pixel, dest_x, dest_y, pixel_word
   logic        rsp_tlast;        // frame_done
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   // Model state
   gfpc_pkg::cfg_type frame_cfg;
   logic [23:0]       palette_shadow [256];
   bit                slot_loaded [256];
   logic [7:0]        loaded_slots [$];
   logic [15:0]       col_count;
   logic [15:0]       row_count;
   logic [1:0]        pass_num;
   bit                frame_over;
   pixel_result_type  expected_pixels [$];

   // Interlace pass tables: first row and row stride
   int unsigned first_row [4] = '{0, 4, 2, 1};
   int unsigned row_stride [4] = '{8, 8, 4, 2};

   // Bench control
   int          mismatches = 0;
   int          random_words = 0;
   bit          gaps_on = 1'b0;
   int          burst_left = 0;
   logic [15:0] stall_pattern = 16'hFFFF;
   logic [3:0]  stall_tick = '0;

   gif_frame_pixel_compositor_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= stall_pattern[stall_tick];
      stall_tick <= stall_tick + 4'd1;
   end

   // Predict the result of one accepted word and update the model state
   function automatic pixel_result_type composite_pixel(input logic [1:0] cmd,
                                                        input logic [7:0] slot,
                                                        input logic [23:0] rgb);
      pixel_result_type res;
      int unsigned      w_eff;
      int unsigned      h_eff;
      int unsigned      next_row;
      logic [23:0]      colour;
      bit               ended;
      res = '0;
      ended = 1'b0;
      if (cmd == gfpc_pkg::CMD_PAL_WRITE) begin
         palette_shadow[slot] = rgb;
         if (!slot_loaded[slot]) begin
            slot_loaded[slot] = 1'b1;
            loaded_slots.push_back(slot);
         end
         return res;
      end
      if (cmd == gfpc_pkg::CMD_START) begin
         col_count = '0;
         row_count = '0;
         pass_num = '0;
         frame_over = 1'b0;
         return res;
      end
      if (cmd != gfpc_pkg::CMD_PIXEL || frame_over)
         return res;

      w_eff = (frame_cfg.frame_width == 0) ? 1 : frame_cfg.frame_width;
      h_eff = (frame_cfg.frame_height == 0) ? 1 : frame_cfg.frame_height;

      // Transparency: skip, background colour, or plain lookup
      res.write_pixel = 1'b1;
      if ((frame_cfg.index_mode == gfpc_pkg::MODE_BACKGROUND ||
           frame_cfg.index_mode == gfpc_pkg::MODE_SKIP)
          && slot == frame_cfg.transparent_index) begin
         if (frame_cfg.index_mode == gfpc_pkg::MODE_SKIP) begin
            res.write_pixel = 1'b0;
         end else begin
            colour = palette_shadow[frame_cfg.background_index];
            res.pixel_word = {gfpc_pkg::ALPHA_OPAQUE, colour};
         end
      end else begin
         colour = palette_shadow[slot];
         res.pixel_word = {gfpc_pkg::ALPHA_OPAQUE, colour};
      end
      res.dest_x = {1'b0, frame_cfg.frame_left} + {1'b0, col_count};
      res.dest_y = {1'b0, frame_cfg.frame_top} + {1'b0, row_count};

      // Column step, then row step at end of line
      col_count = col_count + 16'd1;
      if (col_count >= w_eff || col_count == 16'd0) begin
         col_count = '0;
         if (!frame_cfg.interlaced) begin
            next_row = row_count + 1;
            row_count = next_row[15:0];
            ended = (next_row >= h_eff);
         end else begin
            next_row = row_count + row_stride[pass_num];
            while (!ended && next_row >= h_eff) begin
               if (pass_num == 2'd3) begin
                  ended = 1'b1;
                  next_row = 0;
               end else begin
                  pass_num = pass_num + 2'd1;
                  next_row = first_row[pass_num];
               end
            end
            row_count = next_row[15:0];
         end
      end
      if (ended) begin
         frame_over = 1'b1;
         res.frame_done = 1'b1;
      end
      return res;
   endfunction

   task automatic note_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatches++;
      end
   endtask

   // Result checker
   always @(posedge clock) begin : check_results
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            note_mismatch("write_pixel", want.write_pixel, rsp_tdata[0]);
            note_mismatch("dest_x", want.dest_x, rsp_tdata[17:1]);
            note_mismatch("dest_y", want.dest_y, rsp_tdata[34:18]);
            note_mismatch("pixel_word", want.pixel_word, rsp_tdata[66:35]);
            note_mismatch("frame_done", want.frame_done, rsp_tlast);
         end
      end
   end

   // Send one word, with burst/gap pacing, and log its prediction
   task automatic push_word(input logic [1:0] cmd, input logic [7:0] slot,
                            input logic [23:0] rgb);
      if (gaps_on && burst_left <= 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = cmd;
      req_tdata = {rgb, slot};
      do @(posedge clock); while (!req_tready);
      expected_pixels.push_back(composite_pixel(cmd, slot, rgb));
      burst_left--;
   endtask

   // Stop sending and wait until every expected word is back
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_register(input gfpc_pkg::csr_addr_type addr,
                                 input logic [15:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_addr = addr;
      csr_wdata = value;
      case (addr)
         gfpc_pkg::CSR_FRAME_LEFT:   frame_cfg.frame_left = value;
         gfpc_pkg::CSR_FRAME_TOP:    frame_cfg.frame_top = value;
         gfpc_pkg::CSR_FRAME_WIDTH:  frame_cfg.frame_width = value;
         gfpc_pkg::CSR_FRAME_HEIGHT: frame_cfg.frame_height = value;
         gfpc_pkg::CSR_INTERLACED:   frame_cfg.interlaced = value[0];
         gfpc_pkg::CSR_INDEX_MODE:   frame_cfg.index_mode = value[1:0];
         gfpc_pkg::CSR_TRANSP_INDEX: frame_cfg.transparent_index = value[7:0];
         default:                    frame_cfg.background_index = value[7:0];
      endcase
   endtask

   // Program the whole register set once the block has gone idle
   task automatic apply_frame_config(input logic [15:0] left, input logic [15:0] top,
                                     input logic [15:0] width, input logic [15:0] height,
                                     input logic lace, input logic [1:0] mode,
                                     input logic [7:0] transp, input logic [7:0] bg);
      settle();
      write_register(gfpc_pkg::CSR_FRAME_LEFT, left);
      write_register(gfpc_pkg::CSR_FRAME_TOP, top);
      write_register(gfpc_pkg::CSR_FRAME_WIDTH, width);
      write_register(gfpc_pkg::CSR_FRAME_HEIGHT, height);
      write_register(gfpc_pkg::CSR_INTERLACED, {15'd0, lace});
      write_register(gfpc_pkg::CSR_INDEX_MODE, {14'd0, mode});
      write_register(gfpc_pkg::CSR_TRANSP_INDEX, {8'd0, transp});
      write_register(gfpc_pkg::CSR_BG_INDEX, {8'd0, bg});
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic logic [7:0] pick_loaded_slot();
      return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
   endfunction

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_extent(input int unsigned typical_max);
      case ($urandom_range(0, 11))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h0001;
         default: return 16'($urandom_range(1, typical_max));
      endcase
   endfunction

   // Palette load of extreme colours, a 2x2 frame, late pixel, unused command
   task automatic test_basic_frame();
      stall_pattern = 16'hB6DB;
      apply_frame_config(16'd0, 16'd0, 16'd2, 16'd2, 1'b0, gfpc_pkg::MODE_NONE,
                         8'd0, 8'd0);
      push_word(gfpc_pkg::CMD_PAL_WRITE, 8'h00, 24'h000000);
      push_word(gfpc_pkg::CMD_PAL_WRITE, 8'hFF, 24'hFFFFFF);
      push_word(gfpc_pkg::CMD_PAL_WRITE, 8'h5A, 24'hA55AC3);
      push_word(gfpc_pkg::CMD_PAL_WRITE, 8'hA5, 24'h5AA53C);
      push_word(gfpc_pkg::CMD_START, 8'h00, 24'h000000);
      push_word(gfpc_pkg::CMD_PIXEL, 8'h00, 24'hFFFFFF);
      push_word(gfpc_pkg::CMD_PIXEL, 8'hFF, 24'h000000);
      push_word(gfpc_pkg::CMD_PIXEL, 8'h5A, 24'h123456);
      push_word(gfpc_pkg::CMD_PIXEL, 8'hA5, 24'h654321);
      // pixel once the frame has ended, then the spare command code
      push_word(gfpc_pkg::CMD_PIXEL, 8'h5A, 24'h000000);
      push_word(gfpc_pkg::CMD_RESERVED, 8'hFF, 24'hFFFFFF);
   endtask

   // Background fill, skip, reserved index mode; zero extents at the canvas edge
   task automatic test_transparency();
      apply_frame_config(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b0,
                         gfpc_pkg::MODE_BACKGROUND, 8'hFF, 8'hA5);
      push_word(gfpc_pkg::CMD_START, 8'h00, 24'h000000);
      push_word(gfpc_pkg::CMD_PIXEL, 8'hFF, 24'h000000);
      apply_frame_config(16'h0000, 16'hFFFF, 16'd0, 16'd1, 1'b0,
                         gfpc_pkg::MODE_SKIP, 8'h00, 8'hFF);
      push_word(gfpc_pkg::CMD_START, 8'h00, 24'h000000);
      push_word(gfpc_pkg::CMD_PIXEL, 8'h00, 24'h000000);
      push_word(gfpc_pkg::CMD_START, 8'h00, 24'h000000);
      push_word(gfpc_pkg::CMD_PIXEL, 8'h5A, 24'h000000);
      apply_frame_config(16'hFFFF, 16'h0000, 16'd1, 16'd0, 1'b0,
                         gfpc_pkg::MODE_RESERVED, 8'hFF, 8'h00);
      push_word(gfpc_pkg::CMD_START, 8'h00, 24'h000000);
      push_word(gfpc_pkg::CMD_PIXEL, 8'hFF, 24'h000000);
   endtask

   // Interlaced 1x5 frame: rows come out as 0, 4, 2, 1, 3
   task automatic test_interlace();
      apply_frame_config(16'd7, 16'd3, 16'd1, 16'd5, 1'b1, gfpc_pkg::MODE_NONE,
                         8'h00, 8'h00);
      push_word(gfpc_pkg::CMD_START, 8'h00, 24'h000000);
      repeat (5) push_word(gfpc_pkg::CMD_PIXEL, pick_loaded_slot(), 24'($urandom));
   endtask

   // Random phases of well-formed frames with noise and broken frames mixed in
   task automatic test_random_frames();
      int unsigned area;
      int unsigned frame_len;
      int unsigned phase_words;
      int unsigned roll;
      logic [7:0]  slot;
      while (random_words < 850) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
         apply_frame_config(pick_coord(), pick_coord(), pick_extent(8), pick_extent(12),
                            1'($urandom), 2'($urandom), pick_loaded_slot(),
                            pick_loaded_slot());
         phase_words = $urandom_range(30, 90);
         area = (frame_cfg.frame_width == 0 ? 1 : frame_cfg.frame_width)
                * (frame_cfg.frame_height == 0 ? 1 : frame_cfg.frame_height);
         while (phase_words > 0 && random_words < 850) begin
            // a missing start word leaves the counters where they were
            if ($urandom_range(0, 6) != 0) begin
               push_word(gfpc_pkg::CMD_START, 8'($urandom), 24'($urandom));
               random_words++;
            end
            frame_len = (area <= 120) ? area + $urandom_range(0, 2) : $urandom_range(10, 40);
            repeat (frame_len) begin
               roll = $urandom_range(0, 99);
               if (roll < 5)
                  push_word(gfpc_pkg::CMD_PAL_WRITE, 8'($urandom), 24'($urandom));
               else if (roll < 8)
                  push_word(gfpc_pkg::CMD_RESERVED, 8'($urandom), 24'($urandom));
               else if (roll < 10)
                  push_word(gfpc_pkg::CMD_START, 8'($urandom), 24'($urandom));
               else begin
                  slot = ($urandom_range(0, 3) == 0) ? frame_cfg.transparent_index
                                                     : pick_loaded_slot();
                  push_word(gfpc_pkg::CMD_PIXEL, slot, 24'($urandom));
               end
               random_words++;
            end
            phase_words = (phase_words > frame_len + 1) ? phase_words - frame_len - 1 : 0;
         end
      end
   endtask

   // Run watchdog
   initial begin
      #1_000_000;
      $display("gif_frame_pixel_compositor_core_test NOT OK");
      $finish;
   end

   initial begin
      frame_cfg = '0;
      frame_cfg.frame_width = 16'd1;
      frame_cfg.frame_height = 16'd1;
      col_count = '0;
      row_count = '0;
      pass_num = '0;
      frame_over = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_frame();
      test_transparency();
      test_interlace();
      test_random_frames();

      settle();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("gif_frame_pixel_compositor_core_test OK");
      else
         $display("gif_frame_pixel_compositor_core_test NOT OK");
      $finish;
   end

endmodule

### sim.f
rtl/gfpc_pkg.sv
rtl/gfpc_csr.sv
rtl/gfpc_palette.sv
rtl/gfpc_raster.sv
rtl/gif_frame_pixel_compositor_core.sv
verif/gif_frame_pixel_compositor_core_test.sv
